// File: design/ctcrc_pkg.sv
// Package for the CTC frame run collapse unit: sequencer state, controller
// commands, datapath status and configuration register constants.
// No dependencies.
`default_nettype none

package ctcrc_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int REG_INDEX_LSB = 2;
  localparam logic [0:0] REG_CLASS_COUNT = 1'b0;
  localparam int CLASS_COUNT_W = 6;
  localparam logic [CLASS_COUNT_W-1:0] CLASS_COUNT_RESET = 6'd32;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_CLASS_W = 5;
  localparam int RUN_END_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLD_RD,
    ST_OLD_WR,
    ST_MERGE,
    ST_MERGE_DONE,
    ST_FIN_RD,
    ST_FIN_WR
  } state_t;

  typedef struct packed {
    logic take;
    logic emit_rd;
    logic emit_load;
    logic merge_rd;
    logic merge_done;
    logic stream_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic old_emit;
    logic stream_end;
    logic out_free;
    logic emit_last;
    logic merge_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/ctcrc_ctrl.sv
// Sequencer of the CTC frame run collapse unit: accepts words, then runs the
// emission and merge sweeps at frame end. Depends on ctcrc_pkg.
`default_nettype none

module ctcrc_ctrl
  import ctcrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.take = 1'b1;
          if (status.frame_end) begin
            state_next = status.old_emit ? ST_OLD_RD : ST_MERGE;
          end
        end
      end
      ST_OLD_RD: begin
        cmd.emit_rd = 1'b1;
        state_next = ST_OLD_WR;
      end
      ST_OLD_WR: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          state_next = status.emit_last ? ST_MERGE : ST_OLD_RD;
        end
      end
      ST_MERGE: begin
        cmd.merge_rd = 1'b1;
        if (status.merge_last) begin
          state_next = ST_MERGE_DONE;
        end
      end
      ST_MERGE_DONE: begin
        cmd.merge_done = 1'b1;
        state_next = status.stream_end ? ST_FIN_RD : ST_IDLE;
      end
      ST_FIN_RD: begin
        cmd.emit_rd = 1'b1;
        state_next = ST_FIN_WR;
      end
      ST_FIN_WR: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            cmd.stream_clear = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_FIN_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/ctcrc_dpath.sv
// Datapath of the CTC frame run collapse unit: frame buffer and run maximum
// memories, argmax tracking, frame counter and result register.
// Depends on ctcrc_pkg; driven by ctcrc_ctrl.
`default_nettype none

module ctcrc_dpath
  import ctcrc_pkg::*;
#(
  parameter int MAX_CLASSES = 32,
  parameter int PROB_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ctrl_cmd_t                cmd,
  input  wire logic [CLASS_COUNT_W-1:0] class_count,
  input  wire logic [PROB_BITS-1:0]     prob,
  input  wire logic                     frame_last,
  input  wire logic                     stream_last,
  output dp_status_t                    status,
  output logic                          result_valid,
  input  wire logic                     result_ready,
  output logic [OUT_CLASS_W-1:0]        class_index,
  output logic [PROB_BITS-1:0]          run_max,
  output logic [RUN_END_W-1:0]          run_end,
  output logic [OUT_CLASS_W-1:0]        run_argmax,
  output logic                          vector_last
);

  localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CNTW = $clog2(MAX_CLASSES + 1);
  localparam int CMPW = (CNTW > CLASS_COUNT_W) ? CNTW : CLASS_COUNT_W;

  logic [PROB_BITS-1:0] fb_mem [MAX_CLASSES];
  logic [PROB_BITS-1:0] rms_mem [MAX_CLASSES];

  logic [CW-1:0]        pos;
  logic [PROB_BITS-1:0] best_value;
  logic [CW-1:0]        best_class;
  logic [CW-1:0]        run_class;
  logic [RUN_END_W-1:0] frames_seen;
  logic                 first_pending;
  logic [CW-1:0]        end_pos;
  logic                 sl_q;
  logic                 copy_q;
  logic [CW-1:0]        k;
  logic [CW-1:0]        i;
  logic                 mv;
  logic [CW-1:0]        ma;
  logic [PROB_BITS-1:0] fb_q;
  logic [PROB_BITS-1:0] rms_q;

  logic [CMPW-1:0]      cc_wide;
  logic [CMPW-1:0]      cc_clamp;
  logic [CNTW-1:0]      cc_eff;
  logic                 beats;
  logic [CW-1:0]        best_class_upd;
  logic                 new_run;
  logic [CW-1:0]        rd_addr;
  logic [PROB_BITS-1:0] frame_val;
  logic [PROB_BITS-1:0] merge_val;

  always_comb begin
    cc_wide = CMPW'(class_count);
    if (cc_wide < CMPW'(2)) begin
      cc_clamp = CMPW'(2);
    end else if (cc_wide > CMPW'(MAX_CLASSES)) begin
      cc_clamp = CMPW'(MAX_CLASSES);
    end else begin
      cc_clamp = cc_wide;
    end
    cc_eff = CNTW'(cc_clamp);
  end

  assign beats = prob > best_value;
  assign best_class_upd = beats ? pos : best_class;
  assign new_run = first_pending || (best_class_upd != run_class);

  assign status.frame_end = frame_last || stream_last ||
                            ((CNTW'(pos) + CNTW'(1)) >= cc_eff);
  assign status.old_emit = !first_pending && (best_class_upd != run_class);
  assign status.stream_end = sl_q;
  assign status.out_free = !result_valid || result_ready;
  assign status.emit_last = (CNTW'(k) + CNTW'(1)) == cc_eff;
  assign status.merge_last = i == CW'(MAX_CLASSES - 1);

  assign rd_addr = cmd.merge_rd ? i : k;
  assign frame_val = (ma <= end_pos) ? fb_q : '0;
  assign merge_val = (copy_q || (frame_val > rms_q)) ? frame_val : rms_q;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      fb_mem[pos] <= prob;
    end
    if (cmd.merge_rd) begin
      fb_q <= fb_mem[i];
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      rms_mem[ma] <= merge_val;
    end
    if (cmd.emit_rd || cmd.merge_rd) begin
      rms_q <= rms_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      best_value <= '0;
      best_class <= '0;
      run_class <= '0;
      frames_seen <= '0;
      first_pending <= 1'b1;
      k <= '0;
      i <= '0;
      mv <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        best_class <= best_class_upd;
        if (status.frame_end) begin
          pos <= '0;
          best_value <= '0;
        end else begin
          pos <= pos + CW'(1);
          if (beats) begin
            best_value <= prob;
          end
        end
      end
      if (cmd.merge_rd) begin
        i <= status.merge_last ? '0 : i + CW'(1);
      end
      mv <= cmd.merge_rd;
      if (cmd.merge_done) begin
        run_class <= best_class;
        first_pending <= 1'b0;
        if (frames_seen != '1) begin
          frames_seen <= frames_seen + RUN_END_W'(1);
        end
      end
      if (cmd.emit_load) begin
        k <= status.emit_last ? '0 : k + CW'(1);
      end
      if (cmd.stream_clear) begin
        frames_seen <= '0;
        first_pending <= 1'b1;
        run_class <= '0;
        best_class <= '0;
      end
      if (cmd.emit_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ma <= i;
    if (cmd.take && status.frame_end) begin
      end_pos <= pos;
      sl_q <= stream_last;
      copy_q <= new_run;
    end
    if (cmd.emit_load) begin
      class_index <= OUT_CLASS_W'(k);
      run_max <= rms_q;
      run_end <= frames_seen;
      run_argmax <= OUT_CLASS_W'(run_class);
      vector_last <= status.emit_last;
    end
  end

`ifndef ASSERT_OFF
  a_no_emit_before_first_run: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> !first_pending)
    else $error("result loaded while no run is open");

  a_merge_sweep_in_order: assert property (@(posedge clk) disable iff (rst)
    mv && $past(mv) |-> ma == $past(ma) + CW'(1))
    else $error("merge sweep skipped or repeated an entry");

  a_frame_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (frames_seen < $past(frames_seen)) |-> $past(cmd.stream_clear))
    else $error("frame counter went back outside a stream end");
`endif

endmodule

`default_nettype wire

// File: design/ctc_frame_run_collapse_unit.sv
// Top level of the CTC frame run collapse unit: configuration register and
// the controller and datapath. Depends on ctcrc_pkg, ctcrc_ctrl, ctcrc_dpath.
//
// Class probabilities enter as words on the item channel, one class per word,
// with frame_last and stream_last marking frame and stream ends. Results leave
// on the result channel as vectors of class_count words (2 to MAX_CLASSES),
// one per class, each with the run end frame index and the run argmax;
// vector_last marks the last. A word that does not end a frame leaves the
// block ready for the next word; one that ends a frame holds the block through
// the merge sweep, which passes once over the run maximum memory. Each emitted
// vector adds a read and a load step per result word, set by the single read
// port of that memory; a frame end can emit the ending run first and the final
// run at stream end. The result register lets the block finish a sweep while
// the last word still waits; a stalled receiver holds the block in its emission
// step. Synchronous reset clears the sequencer, counters and run state and sets
// class_count to 32; the memories are not cleared. Register class_count sits
// at byte address 0 of the APB-style port.
`default_nettype none

module ctc_frame_run_collapse_unit
  import ctcrc_pkg::*;
#(
  parameter int MAX_CLASSES = 32,
  parameter int PROB_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire logic [PROB_BITS-1:0]  prob,
  input  wire logic                  frame_last,
  input  wire logic                  stream_last,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic [OUT_CLASS_W-1:0]     class_index,
  output logic [PROB_BITS-1:0]       run_max,
  output logic [RUN_END_W-1:0]       run_end,
  output logic [OUT_CLASS_W-1:0]     run_argmax,
  output logic                       vector_last
);

  logic [CLASS_COUNT_W-1:0] class_count;
  logic [0:0]               reg_index;
  ctrl_cmd_t                cmd;
  dp_status_t               status;

  assign pready = 1'b1;
  assign reg_index = paddr[CFG_ADDR_W-1:REG_INDEX_LSB];

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= CLASS_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && (reg_index == REG_CLASS_COUNT)) begin
      class_count <= pwdata[CLASS_COUNT_W-1:0];
    end
  end

  assign prdata = (reg_index == REG_CLASS_COUNT) ? CFG_DATA_W'(class_count) : '0;

  ctcrc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  ctcrc_dpath #(
    .MAX_CLASSES (MAX_CLASSES),
    .PROB_BITS   (PROB_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .class_count  (class_count),
    .prob         (prob),
    .frame_last   (frame_last),
    .stream_last  (stream_last),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .class_index  (class_index),
    .run_max      (run_max),
    .run_end      (run_end),
    .run_argmax   (run_argmax),
    .vector_last  (vector_last)
  );

endmodule

`default_nettype wire
